FILE: hdl/fca_pkg.sv
package fca_pkg;

    localparam logic [7:0] HDR0      = 8'hAA;
    localparam logic [7:0] HDR1      = 8'h55;
    localparam logic [7:0] ACK_LEN   = 8'h06;
    localparam logic [7:0] MIN_LEN   = 8'd3;

    localparam int unsigned POS_W    = 9;
    localparam int unsigned ACK_N    = 12;
    localparam int unsigned CNT_W    = 4;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HEADER   = 2'd1,
        ST_TAIL     = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

    localparam pos_t POS_HUNT = 9'd0;
    localparam pos_t POS_HDR1 = 9'd1;
    localparam pos_t POS_LEN  = 9'd2;
    localparam pos_t POS_SNDR = 9'd3;
    localparam pos_t POS_ACKF = 9'd5;

    localparam logic ADDR_LOCAL_ID = 1'b0;
    localparam logic ADDR_ACK_TYPE = 1'b1;

endpackage

FILE: hdl/frame_checker_with_ack.sv
// Frame checker with acknowledge.
// Input channel (in_valid / in_stall, rx_byte): one received byte per word.
// Output channel (out_valid / out_stall): status words and ack frame bytes.
// Every byte is checked in the cycle it is accepted; a byte that ends
// something (header error, short length, frame end) loads a result into
// the output register as it is accepted; the result shows in the next cycle.
// A byte that ends nothing gives no result.
// A good frame with a nonzero ack flag gives 12 ack byte words, then the
// status word; while these are output, further input is held off.
// Otherwise throughput is one byte per cycle while the receiver does not
// stall; a new byte is taken in the same cycle the pending status word is taken.
// When the receiver stalls, the pending word holds and input is stalled
// once a result is waiting.
// Reset clears the frame position (hunting for AA), all frame state and
// the output, and restores local_id to 0x20 and ack_type to 0x72.
// APB registers: local_id at 0x0, ack_type at 0x4, low 8 bits used.
module frame_checker_with_ack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [1:0]  status_code,
    output logic [7:0]  ack_byte,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]      local_id_reg;
    logic [7:0]      ack_type_reg;

    fca_pkg::pos_t   pos_reg, pos_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      par_reg, par_next;
    logic [7:0]      sndr_reg, sndr_next;
    logic            ackw_reg, ackw_next;
    logic [7:0]      chk_reg, chk_next;
    logic [1:0]      err_reg, err_next;

    logic            ov_reg, ov_next;
    logic            burst_reg, burst_next;
    fca_pkg::cnt_t   cnt_reg, cnt_next;
    logic [1:0]      st_reg, st_next;

    logic            in_acc;
    logic            out_acc;
    logic            emit;
    logic            emit_ack;
    logic [1:0]      emit_code;
    logic [1:0]      err_end;
    logic            on_status;
    fca_pkg::pos_t   chk_pos;
    fca_pkg::pos_t   len_ext;
    logic [7:0]      parity;
    logic [7:0]      frame_byte;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= 8'h20;
            ack_type_reg <= 8'h72;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                fca_pkg::ADDR_LOCAL_ID: local_id_reg <= pwdata[7:0];
                fca_pkg::ADDR_ACK_TYPE: ack_type_reg <= pwdata[7:0];
                default:                local_id_reg <= local_id_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fca_pkg::ADDR_LOCAL_ID: prdata = {24'd0, local_id_reg};
            fca_pkg::ADDR_ACK_TYPE: prdata = {24'd0, ack_type_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // status word is the one showing when no ack bytes remain
    assign on_status = !burst_reg || (cnt_reg == fca_pkg::cnt_t'(fca_pkg::ACK_N));
    assign out_acc   = ov_reg && !out_stall;
    assign in_stall  = ov_reg && !(out_acc && on_status);
    assign in_acc    = in_valid && !in_stall;

    assign len_ext = {1'b0, len_reg};
    assign chk_pos = len_ext + 9'd3;

    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        par_next  = par_reg;
        sndr_next = sndr_reg;
        ackw_next = ackw_reg;
        chk_next  = chk_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        emit_ack  = 1'b0;
        emit_code = fca_pkg::ST_OK;
        err_end   = err_reg;
        if (rx_byte != fca_pkg::HDR0)
        begin
            err_end = fca_pkg::ST_TAIL;
        end
        priority if (pos_reg == fca_pkg::POS_HUNT)
        begin
            if (rx_byte == fca_pkg::HDR0)
            begin
                pos_next = fca_pkg::POS_HDR1;
            end
            else
            begin
                emit      = 1'b1;
                emit_code = fca_pkg::ST_HEADER;
            end
        end
        else if (pos_reg == fca_pkg::POS_HDR1)
        begin
            if (rx_byte == fca_pkg::HDR1)
            begin
                pos_next = fca_pkg::POS_LEN;
            end
            else
            begin
                emit      = 1'b1;
                emit_code = fca_pkg::ST_HEADER;
                pos_next  = fca_pkg::POS_HUNT;
            end
        end
        else if (pos_reg == fca_pkg::POS_LEN)
        begin
            len_next = rx_byte;
            if (rx_byte < fca_pkg::MIN_LEN)
            begin
                emit      = 1'b1;
                emit_code = fca_pkg::ST_TAIL;
                pos_next  = fca_pkg::POS_HUNT;
            end
            else
            begin
                par_next  = rx_byte;
                err_next  = fca_pkg::ST_OK;
                ackw_next = 1'b0;
                sndr_next = 8'd0;
                chk_next  = 8'd0;
                pos_next  = fca_pkg::POS_SNDR;
            end
        end
        else if (pos_reg < chk_pos)
        begin
            par_next = par_reg ^ rx_byte;
            if (pos_reg == fca_pkg::POS_SNDR)
            begin
                sndr_next = rx_byte;
            end
            if (pos_reg == fca_pkg::POS_ACKF)
            begin
                ackw_next = (rx_byte != 8'd0);
            end
            pos_next = pos_reg + 9'd1;
        end
        else if (pos_reg == chk_pos)
        begin
            chk_next = rx_byte;
            if (rx_byte != par_reg)
            begin
                err_next = fca_pkg::ST_CHECKSUM;
            end
            pos_next = pos_reg + 9'd1;
        end
        else if (pos_reg == chk_pos + 9'd1)
        begin
            if (rx_byte != fca_pkg::HDR1)
            begin
                err_next = fca_pkg::ST_TAIL;
            end
            pos_next = pos_reg + 9'd1;
        end
        else
        begin
            err_next  = err_end;
            emit      = 1'b1;
            emit_code = err_end;
            emit_ack  = (err_end == fca_pkg::ST_OK) && ackw_reg;
            pos_next  = fca_pkg::POS_HUNT;
        end
    end

    always_comb
    begin
        ov_next    = ov_reg;
        burst_next = burst_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        if (out_acc)
        begin
            if (on_status)
            begin
                ov_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
        if (in_acc && emit)
        begin
            ov_next    = 1'b1;
            burst_next = emit_ack;
            cnt_next   = '0;
            st_next    = emit_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= fca_pkg::POS_HUNT;
            len_reg   <= 8'd0;
            par_reg   <= 8'd0;
            sndr_reg  <= 8'd0;
            ackw_reg  <= 1'b0;
            chk_reg   <= 8'd0;
            err_reg   <= fca_pkg::ST_OK;
            ov_reg    <= 1'b0;
            burst_reg <= 1'b0;
            cnt_reg   <= '0;
            st_reg    <= fca_pkg::ST_OK;
        end
        else
        begin
            if (in_acc)
            begin
                pos_reg  <= pos_next;
                len_reg  <= len_next;
                par_reg  <= par_next;
                sndr_reg <= sndr_next;
                ackw_reg <= ackw_next;
                chk_reg  <= chk_next;
                err_reg  <= err_next;
            end
            ov_reg    <= ov_next;
            burst_reg <= burst_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
        end
    end

    assign parity = fca_pkg::ACK_LEN ^ local_id_reg ^ sndr_reg ^ ack_type_reg
                    ^ len_reg ^ chk_reg;

    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    frame_byte = fca_pkg::HDR0;
            4'd1:    frame_byte = fca_pkg::HDR1;
            4'd2:    frame_byte = fca_pkg::ACK_LEN;
            4'd3:    frame_byte = local_id_reg;
            4'd4:    frame_byte = sndr_reg;
            4'd5:    frame_byte = 8'd0;
            4'd6:    frame_byte = ack_type_reg;
            4'd7:    frame_byte = len_reg;
            4'd8:    frame_byte = chk_reg;
            4'd9:    frame_byte = parity;
            4'd10:   frame_byte = fca_pkg::HDR1;
            4'd11:   frame_byte = fca_pkg::HDR0;
            default: frame_byte = 8'd0;
        endcase
    end

    assign out_valid   = ov_reg;
    assign result_kind = !on_status;
    assign status_code = on_status ? st_reg : fca_pkg::ST_OK;
    assign ack_byte    = on_status ? 8'd0 : frame_byte;
    assign last        = on_status;

endmodule

FILE: dv/frame_reply_checker.sv
module frame_reply_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        result_kind,
    input  logic [1:0]  status_code,
    input  logic [7:0]  ack_byte,
    input  logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          pending,
    output int          words_seen,
    output int          acks_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       KIND_STATUS    = 1'b0;
    localparam logic       KIND_ACK       = 1'b1;
    localparam logic [7:0] LOCAL_ID_RESET = 8'h20;
    localparam logic [7:0] ACK_TYPE_RESET = 8'h72;

    typedef struct packed {
        logic             kind;
        fca_pkg::status_t code;
        logic [7:0]       abyte;
        logic             last;
    } word_t;

    word_t            due_words[$];
    word_t            want;
    logic [7:0]       local_id;
    logic [7:0]       ack_type;
    fca_pkg::pos_t    frame_pos;
    logic [7:0]       frame_len;
    logic [7:0]       parity;
    logic [7:0]       sender;
    logic [7:0]       rx_check;
    logic             ack_req;
    fca_pkg::status_t frame_err;
    int               error_total;
    int               word_total;
    int               ack_total;

    task automatic push_status(input fca_pkg::status_t code);
        due_words.push_back('{KIND_STATUS, code, 8'h00, 1'b1});
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        logic [7:0]    reply [fca_pkg::ACK_N];
        fca_pkg::pos_t check_pos;
        int            k;
        check_pos = fca_pkg::pos_t'(frame_len) + fca_pkg::pos_t'(3);
        if (frame_pos == fca_pkg::POS_HUNT) begin
            if (b == fca_pkg::HDR0)
                frame_pos = fca_pkg::POS_HDR1;
            else
                push_status(fca_pkg::ST_HEADER);
        end else if (frame_pos == fca_pkg::POS_HDR1) begin
            if (b == fca_pkg::HDR1) begin
                frame_pos = fca_pkg::POS_LEN;
            end else begin
                push_status(fca_pkg::ST_HEADER);
                frame_pos = fca_pkg::POS_HUNT;
            end
        end else if (frame_pos == fca_pkg::POS_LEN) begin
            frame_len = b;
            if (b < fca_pkg::MIN_LEN) begin
                push_status(fca_pkg::ST_TAIL);
                frame_pos = fca_pkg::POS_HUNT;
            end else begin
                parity    = b;
                frame_err = fca_pkg::ST_OK;
                ack_req   = 1'b0;
                sender    = 8'h00;
                rx_check  = 8'h00;
                frame_pos = fca_pkg::POS_SNDR;
            end
        end else if (frame_pos < check_pos) begin
            parity = parity ^ b;
            if (frame_pos == fca_pkg::POS_SNDR)
                sender = b;
            if (frame_pos == fca_pkg::POS_ACKF)
                ack_req = (b != 8'h00);
            frame_pos = frame_pos + fca_pkg::pos_t'(1);
        end else if (frame_pos == check_pos) begin
            rx_check = b;
            if (b != parity)
                frame_err = fca_pkg::ST_CHECKSUM;
            frame_pos = frame_pos + fca_pkg::pos_t'(1);
        end else if (frame_pos == check_pos + fca_pkg::pos_t'(1)) begin
            if (b != fca_pkg::HDR1)
                frame_err = fca_pkg::ST_TAIL;
            frame_pos = frame_pos + fca_pkg::pos_t'(1);
        end else begin
            if (b != fca_pkg::HDR0)
                frame_err = fca_pkg::ST_TAIL;
            if (frame_err == fca_pkg::ST_OK && ack_req) begin
                reply[0]  = fca_pkg::HDR0;
                reply[1]  = fca_pkg::HDR1;
                reply[2]  = fca_pkg::ACK_LEN;
                reply[3]  = local_id;
                reply[4]  = sender;
                reply[5]  = 8'h00;
                reply[6]  = ack_type;
                reply[7]  = frame_len;
                reply[8]  = rx_check;
                reply[9]  = fca_pkg::ACK_LEN ^ local_id ^ sender ^ ack_type
                            ^ frame_len ^ rx_check;
                reply[10] = fca_pkg::HDR1;
                reply[11] = fca_pkg::HDR0;
                for (k = 0; k < fca_pkg::ACK_N; k++)
                    due_words.push_back('{KIND_ACK, fca_pkg::ST_OK, reply[k], 1'b0});
                ack_total++;
            end
            push_status(frame_err);
            frame_pos = fca_pkg::POS_HUNT;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            local_id    = LOCAL_ID_RESET;
            ack_type    = ACK_TYPE_RESET;
            frame_pos   = fca_pkg::POS_HUNT;
            frame_len   = 8'h00;
            parity      = 8'h00;
            sender      = 8'h00;
            rx_check    = 8'h00;
            ack_req     = 1'b0;
            frame_err   = fca_pkg::ST_OK;
            error_total = 0;
            word_total  = 0;
            ack_total   = 0;
            due_words.delete();
            mismatches <= 0;
            pending    <= 0;
            words_seen <= 0;
            acks_seen  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                word_total++;
                if (due_words.size() == 0) begin
                    $error("unexpected result word: kind %0d status %0d byte %02h last %0d",
                           result_kind, status_code, ack_byte, last);
                    error_total++;
                end else begin
                    want = due_words.pop_front();
                    if (result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        error_total++;
                    end
                    if (status_code !== want.code) begin
                        $error("status_code: expected %0d, got %0d", want.code, status_code);
                        error_total++;
                    end
                    if (ack_byte !== want.abyte) begin
                        $error("ack_byte: expected %02h, got %02h", want.abyte, ack_byte);
                        error_total++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        error_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                decode_rx_byte(rx_byte);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == fca_pkg::ADDR_LOCAL_ID)
                    local_id = pwdata[7:0];
                else
                    ack_type = pwdata[7:0];
            end
            mismatches <= error_total;
            pending    <= due_words.size();
            words_seen <= word_total;
            acks_seen  <= ack_total;
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_GOOD       = 0;
    localparam int TAIL_BAD_FIRST  = 1;
    localparam int TAIL_BAD_SECOND = 2;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte     = 8'h00;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        result_kind;
    logic [1:0]  status_code;
    logic [7:0]  ack_byte;
    logic        last;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int words_seen;
    int acks_seen;
    int bytes_sent = 0;
    bit calm       = 1'b0;

    frame_checker_with_ack i_dut (.*);

    frame_reply_checker i_checker (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 38);

    task automatic send_byte(input logic [7:0] b);
        if (!calm) begin
            while ($urandom_range(99) < 38) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input bit ack, input bit bad_sum,
                              input int tail_fault);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        send_byte(fca_pkg::HDR0);
        send_byte(fca_pkg::HDR1);
        send_byte(len);
        sum = len;
        for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (i == 2)
                b = ack ? 8'($urandom_range(1, 255)) : 8'h00;
            sum = sum ^ b;
            send_byte(b);
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
        send_byte(tail_fault == TAIL_BAD_FIRST ? fca_pkg::HDR1 ^ 8'($urandom_range(1, 255))
                                               : fca_pkg::HDR1);
        send_byte(tail_fault == TAIL_BAD_SECOND ? fca_pkg::HDR0 ^ 8'($urandom_range(1, 255))
                                                : fca_pkg::HDR0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] id, input logic [7:0] kind);
        settle();
        write_reg(fca_pkg::ADDR_LOCAL_ID, id);
        write_reg(fca_pkg::ADDR_ACK_TYPE, kind);
    endtask

    task automatic random_traffic(input int budget);
        int         stop;
        int         r;
        logic [7:0] len;
        logic [7:0] b;
        stop = bytes_sent + budget;
        while (bytes_sent < stop) begin
            r   = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? 8'($urandom_range(13, 40))
                                           : 8'($urandom_range(3, 10));
            if (r < 55) begin
                send_frame(len, 1'($urandom_range(1)), 1'b0, TAIL_GOOD);
            end else if (r < 63) begin
                send_frame(len, 1'($urandom_range(1)), 1'b1, TAIL_GOOD);
            end else if (r < 70) begin
                send_frame(len, 1'($urandom_range(1)), 1'b0, TAIL_BAD_FIRST);
            end else if (r < 77) begin
                send_frame(len, 1'($urandom_range(1)), 1'b0, TAIL_BAD_SECOND);
            end else if (r < 81) begin
                send_frame(len, 1'b1, 1'b1, 1 + $urandom_range(1));
            end else if (r < 90) begin
                send_byte(fca_pkg::HDR0);
                send_byte(fca_pkg::HDR1);
                send_byte(8'($urandom_range(0, 2)));
            end else if (r < 95) begin
                b = 8'($urandom_range(255));
                send_byte(b == fca_pkg::HDR0 ? 8'h00 : b);
            end else begin
                b = 8'($urandom_range(255));
                send_byte(fca_pkg::HDR0);
                send_byte(b == fca_pkg::HDR1 ? fca_pkg::HDR0 : b);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(fca_pkg::HDR0);
        send_byte(fca_pkg::HDR0);
        send_byte(fca_pkg::HDR0);
        send_byte(fca_pkg::HDR1);
        send_byte(8'h02);
        send_frame(8'd3, 1'b1, 1'b0, TAIL_GOOD);
        send_frame(8'd3, 1'b1, 1'b1, TAIL_BAD_FIRST);

        random_traffic(45);

        set_config(8'h00, 8'h00);
        calm <= 1'b1;
        random_traffic(35);
        calm <= 1'b0;

        set_config(8'hFF, 8'hFF);
        send_frame(8'd30, 1'b1, 1'b0, TAIL_GOOD);
        random_traffic(25);

        set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
        random_traffic(25);

        settle();
        $display("run covered %0d rx bytes and %0d result words, %0d of them ack frames,",
                 bytes_sent, words_seen, acks_seen);
        $display("over reset, all-zero, all-one and random ack register settings");
        if (mismatches == 0)
            $display("frame_checker_with_ack regression: pass");
        else
            $display("frame_checker_with_ack regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("frame_checker_with_ack regression: fail");
        $finish;
    end

endmodule
